FILE: design/atan2_pkg.sv
`default_nettype none
package atan2_pkg;
    localparam int ANGLE_W = 23;
    localparam int Q_W     = 25;
    localparam logic [24:0] Q24_ONE     = 25'd16777216;
    localparam logic [23:0] Q24_THIRD   = 24'd5592405;
    localparam logic [23:0] Q24_FIFTH   = 24'd3355443;
    localparam logic [23:0] Q24_SEVENTH = 24'd2396745;
    localparam logic [25:0] Q24_HALF_PI = 26'd26353589;
    localparam logic [25:0] Q24_PI      = 26'd52707179;

    // case flags carried alongside the data up to the quadrant placement stage
    typedef struct packed {
        logic neg_y;
        logic neg_x;
        logic zero_x;
        logic zero_y;
        logic diag;
        logic swap;
    } atan2_flags_t;
endpackage
`default_nettype wire

FILE: design/atan2_divider.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, 24 stages.
// Forms floor(num*2^24/den) for num < den; payload registers are not reset.
module atan2_divider #(
    parameter int MAG_W = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire [MAG_W-1:0]         in_num,
    input  wire [MAG_W-1:0]         in_den,
    input  atan2_pkg::atan2_flags_t in_flags,
    output logic                    out_valid,
    output logic [23:0]             out_q,
    output atan2_pkg::atan2_flags_t out_flags
);
    import atan2_pkg::*;

    localparam int STAGES = 24;

    logic [MAG_W:0]   rem_reg   [STAGES];
    logic [MAG_W-1:0] den_reg   [STAGES];
    logic [23:0]      q_reg     [STAGES];
    atan2_flags_t     flags_reg [STAGES];
    logic [STAGES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic [MAG_W:0]   rem_in;
        logic [MAG_W-1:0] den_in;
        logic [23:0]      q_in;
        atan2_flags_t     flags_in;
        logic [MAG_W+1:0] shifted;
        logic             take;
        if (i == 0) begin : g_first
            assign rem_in   = {1'b0, in_num};
            assign den_in   = in_den;
            assign q_in     = '0;
            assign flags_in = in_flags;
        end else begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign q_in     = q_reg[i-1];
            assign flags_in = flags_reg[i-1];
        end
        assign shifted = {rem_in, 1'b0};
        assign take    = shifted >= {2'b00, den_in};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]   <= take ? (MAG_W+1)'(shifted - {2'b00, den_in})
                                     : shifted[MAG_W:0];
                den_reg[i]   <= den_in;
                q_reg[i]     <= {q_in[22:0], take};
                flags_reg[i] <= flags_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_q     = q_reg[STAGES-1];
    assign out_flags = flags_reg[STAGES-1];
endmodule
`default_nettype wire

FILE: design/atan2_poly.sv
`default_nettype none
// Horner evaluation of the odd polynomial, at most one multiply per register stage.
module atan2_poly (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire [23:0]              in_q,
    input  atan2_pkg::atan2_flags_t in_flags,
    output logic                    out_valid,
    output logic [22:0]             out_angle
);
    import atan2_pkg::*;

    localparam int ST = 7;

    logic [ST-1:0] valid_reg;
    atan2_flags_t  flags_reg [6];
    logic [24:0]   r_reg     [5];
    logic [24:0]   r2_reg;
    logic [24:0]   r2_d_reg  [2:3];
    logic [23:0]   u_reg, v_reg;
    logic [24:0]   w_reg;
    logic [24:0]   a_reg;
    logic [22:0]   out_reg;

    logic [24:0] r_in;
    logic [49:0] m_rr;
    logic [48:0] m_u, m_v, m_w;
    logic [49:0] m_p;
    logic [25:0] a_fin, m_fin;
    logic [26:0] rnd;
    logic [22:0] mag;

    assign r_in = in_flags.diag ? Q24_ONE : {1'b0, in_q};
    assign m_rr = r_reg[0] * r_reg[0];
    assign m_u  = r2_reg * Q24_SEVENTH;
    assign m_v  = r2_d_reg[2] * u_reg;
    assign m_w  = r2_d_reg[3] * v_reg;
    assign m_p  = r_reg[4] * w_reg;

    always_comb begin
        a_fin = flags_reg[5].swap ? Q24_HALF_PI - {1'b0, a_reg} : {1'b0, a_reg};
        m_fin = flags_reg[5].neg_x ? Q24_PI - a_fin : a_fin;
        if (flags_reg[5].zero_x && flags_reg[5].zero_y) begin
            m_fin = '0;
        end else if (flags_reg[5].zero_x) begin
            m_fin = Q24_HALF_PI;
        end else if (flags_reg[5].zero_y) begin
            m_fin = flags_reg[5].neg_x ? Q24_PI : '0;
        end
        rnd = {1'b0, m_fin} + 27'd8;
        mag = rnd[26:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]     <= r_in;
            flags_reg[0] <= in_flags;
            for (int i = 1; i < 6; i++) begin
                flags_reg[i] <= flags_reg[i-1];
            end
            for (int i = 1; i < 5; i++) begin
                r_reg[i] <= r_reg[i-1];
            end
            r2_reg      <= m_rr[48:24];
            u_reg       <= Q24_FIFTH - m_u[47:24];
            r2_d_reg[2] <= r2_reg;
            v_reg       <= Q24_THIRD - m_v[47:24];
            r2_d_reg[3] <= r2_d_reg[2];
            w_reg       <= Q24_ONE - m_w[48:24];
            a_reg       <= m_p[48:24];
            out_reg     <= flags_reg[5].neg_y && !(flags_reg[5].zero_y && !flags_reg[5].zero_x)
                           ? 23'(-mag) : mag;
        end
    end

    assign out_valid = valid_reg[ST-1];
    assign out_angle = out_reg;
endmodule
`default_nettype wire

FILE: design/atan2_polynomial_angle_unit.sv
`default_nettype none
// Four-quadrant arctangent of a signed (y, x) pair, angle out in radians as
// signed Q3.20. Fully pipelined: one transaction in per cycle while the output
// is not stalled. The pipeline has 1 input stage, 24 divider stages for the
// octant ratio, and 7 stages of Horner polynomial, quadrant placement and
// output register. Backpressure stalls the whole pipeline.
module atan2_polynomial_angle_unit #(
    parameter int IN_WIDTH = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [2*IN_WIDTH-1:0] s_tdata,  // x_value (upper half), y_value (lower half)
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [23:0]          m_tdata   // zero pad (bit 23), angle_rad
);
    import atan2_pkg::*;

    logic en;
    logic [IN_WIDTH-1:0] y_raw, x_raw, ay, ax;
    logic ny, nx;
    logic v0_reg;
    logic [IN_WIDTH-1:0] num_reg, den_reg;
    atan2_flags_t f0_reg;
    logic d_valid;
    logic [23:0] d_q;
    atan2_flags_t d_flags;
    logic p_valid;
    logic [22:0] p_angle;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign y_raw = s_tdata[IN_WIDTH-1:0];
    assign x_raw = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
    assign ny = y_raw[IN_WIDTH-1];
    assign nx = x_raw[IN_WIDTH-1];
    assign ay = ny ? IN_WIDTH'(-y_raw) : y_raw;
    assign ax = nx ? IN_WIDTH'(-x_raw) : x_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg       <= (ay > ax) ? ax : ay;
            den_reg       <= (ay > ax) ? ay : ax;
            f0_reg.neg_y  <= ny;
            f0_reg.neg_x  <= nx;
            f0_reg.zero_x <= ax == '0;
            f0_reg.zero_y <= ay == '0;
            f0_reg.diag   <= ay == ax;
            f0_reg.swap   <= ay > ax;
        end
    end

    atan2_divider #(.MAG_W(IN_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg), .in_num(num_reg), .in_den(den_reg), .in_flags(f0_reg),
        .out_valid(d_valid), .out_q(d_q), .out_flags(d_flags)
    );

    atan2_poly u_poly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d_valid), .in_q(d_q), .in_flags(d_flags),
        .out_valid(p_valid), .out_angle(p_angle)
    );

    assign m_tvalid = p_valid;
    assign m_tdata  = {1'b0, p_angle};
endmodule
`default_nettype wire

FILE: bench/atan2_polynomial_angle_unit_tb.sv
`default_nettype none
module atan2_polynomial_angle_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = 32;
    localparam logic [63:0] C_ONE   = 64'd16777216;
    localparam logic [63:0] C_THIRD = 64'd5592405;
    localparam logic [63:0] C_FIFTH = 64'd3355443;
    localparam logic [63:0] C_SEVEN = 64'd2396745;
    localparam logic [63:0] C_HPI   = 64'd26353589;
    localparam logic [63:0] C_PI    = 64'd52707179;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*IN_W-1:0]   s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;

    logic [22:0] angle_queue[$];
    int          error_count = 0;
    int          hold_off_cycles = 0;
    bit          steady_sink = 1'b0;

    atan2_polynomial_angle_unit #(.IN_WIDTH(IN_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] octant_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q = 0;
        for (int i = 0; i < 24; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [22:0] signed_angle(logic [63:0] mag24, bit neg);
        logic [63:0] m;
        m = (mag24 + 64'd8) >> 4;
        return neg ? 23'(64'd0 - m) : 23'(m);
    endfunction

    function automatic logic [22:0] predict_angle(logic [31:0] y, logic [31:0] x);
        logic [63:0] ay, ax, r, r2, u, v, w, a, m;
        bit ny, nx;
        ny = y[31];
        nx = x[31];
        ay = ny ? {32'd0, 32'(-y)} : {32'd0, y};
        ax = nx ? {32'd0, 32'(-x)} : {32'd0, x};
        if (ax == 0 && ay == 0) return 23'd0;
        if (ax == 0) return signed_angle(C_HPI, ny);
        if (ay == 0) return nx ? signed_angle(C_PI, 1'b0) : 23'd0;
        if (ay == ax) r = C_ONE;
        else if (ay < ax) r = octant_ratio(ay, ax);
        else r = octant_ratio(ax, ay);
        r2 = (r * r) >> 24;
        u = C_FIFTH - ((r2 * C_SEVEN) >> 24);
        v = C_THIRD - ((r2 * u) >> 24);
        w = C_ONE - ((r2 * v) >> 24);
        a = (r * w) >> 24;
        if (ay > ax) a = C_HPI - a;
        m = nx ? (C_PI - a) : a;
        return signed_angle(m, ny);
    endfunction

    // hold the pair until the transaction completes
    task automatic send_pair(logic [31:0] y, logic [31:0] x);
        s_tvalid <= 1'b1;
        s_tdata  <= {x, y};
        angle_queue.push_back(predict_angle(y, x));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic send_burst_gap(logic [31:0] y, logic [31:0] x);
        send_pair(y, x);
        if ($urandom_range(0, 7) == 0) idle_sender();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15);
            1: return -$urandom_range(0, 15);
            2: return MOST_NEG;
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_axes_and_extremes();
        logic [31:0] vals[6] = '{32'd0, 32'd1, MOST_POS, MOST_NEG, 32'hFFFF_FFFF, 32'd1000};
        foreach (vals[i]) send_pair(vals[i], 32'd0);
        foreach (vals[i]) send_pair(32'd0, vals[i]);
        send_pair(32'd7, 32'd7);
        send_pair(-32'd7, 32'd7);
        send_pair(32'd7, -32'd7);
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_POS, MOST_NEG);
        send_pair(MOST_NEG, MOST_POS);
        send_pair(32'd1, MOST_POS);
        send_pair(MOST_POS, -32'd1);
        drain();
    endtask

    task automatic test_random_stream(int n);
        for (int i = 0; i < n; i++) begin
            send_burst_gap(random_component(), random_component());
        end
        drain();
    endtask

    // block the output while the sender keeps pushing
    task automatic test_backpressure();
        hold_off_cycles = 200;
        for (int i = 0; i < 120; i++) send_pair($urandom, $urandom);
        drain();
    endtask

    task automatic test_full_rate();
        steady_sink = 1'b1;
        for (int i = 0; i < 150; i++) send_pair($urandom, $urandom);
        drain();
        steady_sink = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else if (steady_sink) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected angle %h", $realtime, m_tdata[22:0]);
                error_count++;
            end else begin
                logic [22:0] want;
                want = angle_queue.pop_front();
                if (m_tdata[22:0] !== want) begin
                    $display("%0t: angle_rad expected %h actual %h",
                             $realtime, want, m_tdata[22:0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_axes_and_extremes();
        test_random_stream(520);
        test_backpressure();
        test_full_rate();
        test_random_stream(140);
        repeat (40) @(posedge aclk);
        if (error_count == 0 && angle_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
